/* src/gray_histogram_equalizer_unit_defines.svh */
// Assertion macros used by the histogram equalizer checker.
// Needs nothing else; include it with the bare file name.
`ifndef GRAY_HISTOGRAM_EQUALIZER_UNIT_DEFINES_SVH
`define GRAY_HISTOGRAM_EQUALIZER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define GHE_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("check failed in %m");

// Next-cycle implication, disabled while reset is high.
`define GHE_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("check failed in %m");

// Next-cycle implication that also holds across reset.
`define GHE_ASSERT_NEXT_ALWAYS(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("check failed in %m");

`endif

/* src/ghe_pkg.sv */
// Shared types and constants of the gray histogram equalizer.
// Used by the top level and the port checker; depends on nothing.
package ghe_pkg;

  localparam logic OP_COUNT = 1'b0;
  localparam logic OP_MAP   = 1'b1;

  localparam int         QUO_BITS = 8;
  localparam logic [7:0] GRAY_MAX = 8'd255;

  typedef struct packed {
    logic       op;
    logic [7:0] pixel_gray;
    logic [7:0] pixel_alpha;
    logic       last_pixel;
  } pix_beat_t;

  typedef struct packed {
    logic [7:0] out_gray;
    logic [7:0] out_alpha;
    logic       out_last;
  } res_beat_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_RUN,
    ST_WAIT,
    ST_MIN_RD,
    ST_MIN_GET,
    ST_RD,
    ST_ACC,
    ST_PREP,
    ST_DIV
  } state_t;

endpackage

/* src/ghe_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; contents are undefined until written.
module ghe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/gray_histogram_equalizer_unit.sv */
// Gray histogram equalizer top level; uses ghe_pkg and two ghe_ram instances.
// Count and map pixels are taken one beat per cycle while pix_stall is low; a map result
// passes stage 1 (registered map RAM read) and the output register. After the last count pixel
// the table build does one bin RAM read and, where needed, an 8-step shift-subtract divider
// per table entry. Reset and the last map pixel start a bin clearing pass (bin RAM write port).
// Reset is synchronous and active high; no pixel is taken during a build or a clearing pass.
module gray_histogram_equalizer_unit #(
  parameter int GRAY_LEVELS = 256,
  parameter int COUNT_BITS  = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pix_valid,
  output logic                pix_stall,
  input  ghe_pkg::pix_beat_t  pix,
  output logic                res_valid,
  input  logic                res_stall,
  output ghe_pkg::res_beat_t  res
);

  // Level index width, and a compare width that covers both the 8-bit gray input and the index.
  localparam int LVL_W = $clog2(GRAY_LEVELS);
  localparam int GW    = (LVL_W > 8) ? LVL_W : 8;
  localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(GRAY_LEVELS - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  // The cumulative sum of all bins needs LVL_W more bits than one bin.
  localparam int CDF_W = COUNT_BITS + LVL_W;
  // The dividend 510*num + den stays below 512 * 2^COUNT_BITS.
  localparam int N_W   = COUNT_BITS + 9;

  ghe_pkg::state_t state, state_next;
  logic [LVL_W-1:0] sweep, sweep_next;

  // Frame statistics kept next to the bin RAM.
  logic [COUNT_BITS-1:0] total;
  logic [LVL_W-1:0]      min_lvl;

  // Stage 1: the beat whose RAM read is in flight.
  logic                  s1_valid;
  logic                  s1_op;
  logic                  s1_last;
  logic [7:0]            s1_alpha;
  logic [LVL_W-1:0]      s1_lvl;
  logic                  s1_fwd;
  logic [COUNT_BITS-1:0] s1_fwd_cnt;

  // Table build datapath.
  logic [COUNT_BITS-1:0] cdfmin;
  logic [COUNT_BITS-1:0] den;
  logic                  ident;
  logic [CDF_W-1:0]      cdf;
  logic [N_W-1:0]        rem;
  logic [N_W-1:0]        dsh;
  logic [7:0]            quo;
  logic [2:0]            step;

  // RAM ports.
  logic                  bin_we, bin_re;
  logic [LVL_W-1:0]      bin_waddr, bin_raddr;
  logic [COUNT_BITS-1:0] bin_wdata, bin_rdata;
  logic                  map_we, map_re;
  logic [LVL_W-1:0]      map_waddr, map_raddr;
  logic [7:0]            map_wdata, map_rdata;

  logic                  pix_accept;
  logic [GW-1:0]         gray_w;
  logic [LVL_W-1:0]      pix_lvl;
  logic                  s1_block;
  logic                  cnt_wr;
  logic [COUNT_BITS-1:0] bin_cur;
  logic [COUNT_BITS-1:0] bin_inc;
  logic [CDF_W-1:0]      num_full;
  logic [COUNT_BITS-1:0] num;
  logic                  quo_bit;
  logic [7:0]            quo_new;
  logic                  div_start;

  ghe_ram #(.WIDTH(COUNT_BITS), .DEPTH(GRAY_LEVELS)) u_bin_ram (
    .clk   (clk),
    .we    (bin_we),
    .waddr (bin_waddr),
    .wdata (bin_wdata),
    .re    (bin_re),
    .raddr (bin_raddr),
    .rdata (bin_rdata)
  );

  ghe_ram #(.WIDTH(8), .DEPTH(GRAY_LEVELS)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // A gray level beyond the table uses the last bin and the last table entry.
  assign gray_w  = GW'(pix.pixel_gray);
  assign pix_lvl = (gray_w < GW'(GRAY_LEVELS - 1)) ? LVL_W'(gray_w) : LAST_LVL;

  // A map beat in stage 1 can only move on when the output register is free or being taken.
  assign s1_block   = s1_valid && (s1_op == ghe_pkg::OP_MAP) && res_valid && res_stall;
  assign pix_stall  = (state != ghe_pkg::ST_RUN) || s1_block;
  assign pix_accept = pix_valid && !pix_stall;

  // Count beats do read-modify-write on the bin RAM. When the previous count beat writes the
  // same bin on the edge where this beat's read is sampled, the RAM returns the old count, so
  // the written value is forwarded instead.
  assign cnt_wr  = s1_valid && (s1_op == ghe_pkg::OP_COUNT);
  assign bin_cur = s1_fwd ? s1_fwd_cnt : bin_rdata;
  assign bin_inc = (bin_cur == CNT_MAX) ? CNT_MAX : bin_cur + 1'b1;

  // Table entry arithmetic: q = floor((510*num + den) / (2*den)), with num < den here.
  assign num_full = cdf - CDF_W'(cdfmin);
  assign num      = COUNT_BITS'(num_full);
  assign quo_bit  = (rem >= dsh);
  assign quo_new  = {quo[6:0], quo_bit};

  always_comb begin
    state_next = state;
    sweep_next = sweep;
    div_start  = 1'b0;

    bin_we    = cnt_wr;
    bin_waddr = s1_lvl;
    bin_wdata = bin_inc;
    bin_re    = pix_accept && (pix.op == ghe_pkg::OP_COUNT);
    bin_raddr = pix_lvl;

    map_we    = 1'b0;
    map_waddr = sweep;
    map_wdata = '0;
    map_re    = pix_accept && (pix.op == ghe_pkg::OP_MAP);
    map_raddr = pix_lvl;

    case (state)
      ghe_pkg::ST_CLEAR: begin
        bin_we    = 1'b1;
        bin_waddr = sweep;
        bin_wdata = '0;
        if (sweep == LAST_LVL) begin
          state_next = ghe_pkg::ST_RUN;
        end else begin
          sweep_next = sweep + 1'b1;
        end
      end
      ghe_pkg::ST_RUN: begin
        if (pix_accept && pix.last_pixel) begin
          if (pix.op == ghe_pkg::OP_COUNT) begin
            state_next = ghe_pkg::ST_WAIT;
          end else begin
            state_next = ghe_pkg::ST_CLEAR;
            sweep_next = '0;
          end
        end
      end
      ghe_pkg::ST_WAIT: begin
        // The last count beat writes its bin in this cycle.
        state_next = ghe_pkg::ST_MIN_RD;
      end
      ghe_pkg::ST_MIN_RD: begin
        bin_re     = 1'b1;
        bin_raddr  = min_lvl;
        state_next = ghe_pkg::ST_MIN_GET;
      end
      ghe_pkg::ST_MIN_GET: begin
        sweep_next = '0;
        state_next = ghe_pkg::ST_RD;
      end
      ghe_pkg::ST_RD: begin
        bin_re     = 1'b1;
        bin_raddr  = sweep;
        state_next = ghe_pkg::ST_ACC;
      end
      ghe_pkg::ST_ACC: begin
        state_next = ghe_pkg::ST_PREP;
      end
      ghe_pkg::ST_PREP: begin
        map_we = 1'b1;
        if (ident) begin
          map_wdata = 8'(sweep);
        end else if (cdf == '0) begin
          map_wdata = '0;
        end else if (num_full >= CDF_W'(den)) begin
          map_wdata = ghe_pkg::GRAY_MAX;
        end else begin
          map_we    = 1'b0;
          div_start = 1'b1;
        end
        if (div_start) begin
          state_next = ghe_pkg::ST_DIV;
        end else if (sweep == LAST_LVL) begin
          state_next = ghe_pkg::ST_RUN;
        end else begin
          sweep_next = sweep + 1'b1;
          state_next = ghe_pkg::ST_RD;
        end
      end
      ghe_pkg::ST_DIV: begin
        if (step == 3'(ghe_pkg::QUO_BITS - 1)) begin
          map_we    = 1'b1;
          map_wdata = quo_new;
          if (sweep == LAST_LVL) begin
            state_next = ghe_pkg::ST_RUN;
          end else begin
            sweep_next = sweep + 1'b1;
            state_next = ghe_pkg::ST_RD;
          end
        end
      end
      default: begin
        state_next = ghe_pkg::ST_CLEAR;
        sweep_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ghe_pkg::ST_CLEAR;
      sweep     <= '0;
      total     <= '0;
      min_lvl   <= LAST_LVL;
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      sweep <= sweep_next;

      // The bins are cleared in the same pass, so the frame statistics restart too.
      if (state == ghe_pkg::ST_CLEAR) begin
        total   <= '0;
        min_lvl <= LAST_LVL;
      end else if (pix_accept && (pix.op == ghe_pkg::OP_COUNT)) begin
        total   <= (total == CNT_MAX) ? CNT_MAX : total + 1'b1;
        min_lvl <= (pix_lvl < min_lvl) ? pix_lvl : min_lvl;
      end

      if (pix_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_valid && !s1_block) begin
        s1_valid <= 1'b0;
      end

      if (s1_valid && (s1_op == ghe_pkg::OP_MAP) && !s1_block) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (pix_accept) begin
      s1_op      <= pix.op;
      s1_last    <= pix.last_pixel;
      s1_alpha   <= pix.pixel_alpha;
      s1_lvl     <= pix_lvl;
      s1_fwd     <= cnt_wr && (s1_lvl == pix_lvl);
      s1_fwd_cnt <= bin_inc;
    end

    if (s1_valid && (s1_op == ghe_pkg::OP_MAP) && !s1_block) begin
      res.out_gray  <= map_rdata;
      res.out_alpha <= s1_alpha;
      res.out_last  <= s1_last;
    end

    // The first nonzero bin gives cdfmin; an empty spread makes the table the identity.
    if (state == ghe_pkg::ST_MIN_GET) begin
      cdfmin <= bin_rdata;
      ident  <= (total <= bin_rdata);
      den    <= total - bin_rdata;
      cdf    <= '0;
    end

    if (state == ghe_pkg::ST_ACC) begin
      cdf <= cdf + CDF_W'(bin_rdata);
    end

    if (div_start) begin
      rem  <= (N_W'(num) << 9) - (N_W'(num) << 1) + N_W'(den);
      dsh  <= N_W'(den) << 8;
      quo  <= '0;
      step <= '0;
    end else if (state == ghe_pkg::ST_DIV) begin
      if (quo_bit) begin
        rem <= rem - dsh;
      end
      dsh  <= dsh >> 1;
      quo  <= quo_new;
      step <= step + 1'b1;
    end
  end

endmodule

/* src/ghe_checker.sv */
// Port-level checker for the gray histogram equalizer, bound to the top level.
// Depends on ghe_pkg and the assertion macros in the defines header.
`include "gray_histogram_equalizer_unit_defines.svh"

module ghe_checker (
  input logic               clk,
  input logic               rst,
  input logic               pix_valid,
  input logic               pix_stall,
  input ghe_pkg::pix_beat_t pix,
  input logic               res_valid,
  input logic               res_stall,
  input ghe_pkg::res_beat_t res
);

  // A map pixel beat taken at this edge.
  logic map_take;
  assign map_take = pix_valid && !pix_stall && (pix.op == ghe_pkg::OP_MAP);

  // A stalled result beat stays and keeps its payload.
  `GHE_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid && $stable(res))

  // A new result appears only after a map pixel was taken; the beat passes one stage first.
  `GHE_ASSERT_NOW(a_res_cause, clk, rst, $rose(res_valid), $past(map_take, 2))

  // The last pixel of either pass starts a build or a clearing pass.
  `GHE_ASSERT_NEXT(a_last_stalls, clk, rst, pix_valid && !pix_stall && pix.last_pixel, pix_stall)

  // Reset starts the clearing pass, so no pixel is taken right after it.
  `GHE_ASSERT_NEXT_ALWAYS(a_rst_stalls, clk, rst, pix_stall)

endmodule

bind gray_histogram_equalizer_unit ghe_checker u_ghe_checker (.*);
